/* rtl/core/complex_arith_unit_core_defines.svh */
// Assertion macros for the complex arithmetic unit RTL, used by its top level.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef COMPLEX_ARITH_UNIT_CORE_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_CORE_DEFINES_SVH

// Same-cycle implication.
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cau_pkg.sv */
// Shared types for the complex arithmetic unit: command and status codes,
// and the control word that travels down the pipeline. No dependencies.
package cau_pkg;

  localparam int unsigned CMD_BITS    = 3;
  localparam int unsigned STATUS_BITS = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_MAG = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_e;

  typedef struct packed {
    logic [CMD_BITS-1:0] cmd;
    logic                neg_re;
    logic                neg_im;
    logic                big_re;
    logic                big_im;
    status_e             status;
  } ctl_t;

endpackage

/* rtl/core/cau_front.sv */
// Front pipeline of the complex arithmetic unit: operand capture, products,
// sums and add/sub/multiply results. Depends on cau_pkg.
module cau_front
  import cau_pkg::*;
#(
  parameter int unsigned WORD_BITS     = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [CMD_BITS-1:0]         cmd_i,
  input  logic signed [WORD_BITS-1:0] a_re_i,
  input  logic signed [WORD_BITS-1:0] a_im_i,
  input  logic signed [WORD_BITS-1:0] b_re_i,
  input  logic signed [WORD_BITS-1:0] b_im_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output ctl_t                        ctl_o,
  output logic signed [WORD_BITS-1:0] res_re_o,
  output logic signed [WORD_BITS-1:0] res_im_o,
  output logic [2*WORD_BITS-1:0]      num_re_o,
  output logic [2*WORD_BITS-1:0]      num_im_o,
  output logic [2*WORD_BITS-1:0]      den_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned PW = 2 * WORD_BITS;
  localparam int unsigned F  = FRACTION_BITS;

  localparam logic signed [PW:0] SMAX = {{(PW-W+2){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [PW:0] SMIN = {{(PW-W+2){1'b1}}, {(W-1){1'b0}}};

  function automatic logic [W:0] sat_w(input logic signed [PW:0] v);
    if (v > SMAX) begin
      return {1'b1, SMAX[W-1:0]};
    end else if (v < SMIN) begin
      return {1'b1, SMIN[W-1:0]};
    end
    return {1'b0, v[W-1:0]};
  endfunction

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4     = !v4_q || ready_i;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: operands
  logic [CMD_BITS-1:0] cmd1_q;
  logic signed [W-1:0] ar1_q, ai1_q, br1_q, bi1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      cmd1_q <= cmd_i;
      ar1_q  <= a_re_i;
      ai1_q  <= a_im_i;
      br1_q  <= b_re_i;
      bi1_q  <= b_im_i;
    end
  end

  // stage 2: products and add/sub sums
  logic signed [PW-1:0] prr_d, pii_d, pri_d, pir_d, sq1_d, sq2_d;
  logic signed [W-1:0]  m1_op, m2_op;
  logic signed [W:0]    as_re_d, as_im_d;
  logic [CMD_BITS-1:0]  cmd2_q;
  logic signed [PW-1:0] prr_q, pii_q, pri_q, pir_q, sq1_q, sq2_q;
  logic signed [W:0]    as_re_q, as_im_q;

  always_comb begin
    m1_op = (cmd1_q == CMD_MAG) ? ar1_q : br1_q;
    m2_op = (cmd1_q == CMD_MAG) ? ai1_q : bi1_q;
    prr_d = ar1_q * br1_q;
    pii_d = ai1_q * bi1_q;
    pri_d = ar1_q * bi1_q;
    pir_d = ai1_q * br1_q;
    sq1_d = m1_op * m1_op;
    sq2_d = m2_op * m2_op;
    if (cmd1_q == CMD_SUB) begin
      as_re_d = {ar1_q[W-1], ar1_q} - {br1_q[W-1], br1_q};
      as_im_d = {ai1_q[W-1], ai1_q} - {bi1_q[W-1], bi1_q};
    end else begin
      as_re_d = {ar1_q[W-1], ar1_q} + {br1_q[W-1], br1_q};
      as_im_d = {ai1_q[W-1], ai1_q} + {bi1_q[W-1], bi1_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      cmd2_q  <= cmd1_q;
      prr_q   <= prr_d;
      pii_q   <= pii_d;
      pri_q   <= pri_d;
      pir_q   <= pir_d;
      sq1_q   <= sq1_d;
      sq2_q   <= sq2_d;
      as_re_q <= as_re_d;
      as_im_q <= as_im_d;
    end
  end

  // stage 3: cross sums
  logic signed [PW:0]  tre_d, tim_d;
  logic [PW-1:0]       den_d;
  logic [CMD_BITS-1:0] cmd3_q;
  logic signed [PW:0]  tre_q, tim_q;
  logic [PW-1:0]       den_q;
  logic signed [W:0]   as3_re_q, as3_im_q;

  always_comb begin
    if (cmd2_q == CMD_MUL) begin
      tre_d = {prr_q[PW-1], prr_q} - {pii_q[PW-1], pii_q};
      tim_d = {pri_q[PW-1], pri_q} + {pir_q[PW-1], pir_q};
    end else begin
      tre_d = {prr_q[PW-1], prr_q} + {pii_q[PW-1], pii_q};
      tim_d = {pir_q[PW-1], pir_q} - {pri_q[PW-1], pri_q};
    end
    den_d = PW'(sq1_q) + PW'(sq2_q);
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      cmd3_q   <= cmd2_q;
      tre_q    <= tre_d;
      tim_q    <= tim_d;
      den_q    <= den_d;
      as3_re_q <= as_re_q;
      as3_im_q <= as_im_q;
    end
  end

  // stage 4: finish add/sub/multiply, set up divide and magnitude
  logic signed [PW:0] sh_re, sh_im, abs_re, abs_im;
  logic [W:0]         s_re, s_im;
  ctl_t               ctl_d;
  logic [W-1:0]       res_re_d, res_im_d;

  always_comb begin
    sh_re  = tre_q >>> F;
    sh_im  = tim_q >>> F;
    abs_re = tre_q[PW] ? -tre_q : tre_q;
    abs_im = tim_q[PW] ? -tim_q : tim_q;
    s_re   = '0;
    s_im   = '0;
    ctl_d        = '0;
    ctl_d.cmd    = cmd3_q;
    ctl_d.neg_re = tre_q[PW];
    ctl_d.neg_im = tim_q[PW];
    ctl_d.status = ST_OK;
    unique case (cmd3_q) inside
      CMD_ADD, CMD_SUB: begin
        s_re = sat_w({{(PW-W){as3_re_q[W]}}, as3_re_q});
        s_im = sat_w({{(PW-W){as3_im_q[W]}}, as3_im_q});
      end
      CMD_MUL: begin
        s_re = sat_w(sh_re);
        s_im = sat_w(sh_im);
      end
      CMD_DIV: begin
        if (den_q == '0) ctl_d.status = ST_DIV0;
      end
      default: ;
    endcase
    if (s_re[W] || s_im[W]) ctl_d.status = ST_OVF;
    res_re_d = s_re[W-1:0];
    res_im_d = s_im[W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      ctl_o    <= ctl_d;
      res_re_o <= res_re_d;
      res_im_o <= res_im_d;
      num_re_o <= abs_re[PW-1:0];
      num_im_o <= abs_im[PW-1:0];
      den_o    <= den_q;
    end
  end

endmodule

/* rtl/core/cau_iter.sv */
// Bit-per-stage pipeline of the complex arithmetic unit: two restoring
// dividers and one square root, one result bit per stage. Depends on cau_pkg.
module cau_iter
  import cau_pkg::*;
#(
  parameter int unsigned WORD_BITS     = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  ctl_t                        ctl_i,
  input  logic signed [WORD_BITS-1:0] res_re_i,
  input  logic signed [WORD_BITS-1:0] res_im_i,
  input  logic [2*WORD_BITS-1:0]      num_re_i,
  input  logic [2*WORD_BITS-1:0]      num_im_i,
  input  logic [2*WORD_BITS-1:0]      den_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output ctl_t                        ctl_o,
  output logic signed [WORD_BITS-1:0] res_re_o,
  output logic signed [WORD_BITS-1:0] res_im_o,
  output logic [WORD_BITS-1:0]        q_re_o,
  output logic [WORD_BITS-1:0]        q_im_o,
  output logic [WORD_BITS-1:0]        root_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned PW = 2 * WORD_BITS;
  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned XW = PW + F;
  localparam int unsigned N  = W + 1;

  typedef struct packed {
    ctl_t          ctl;
    logic [W-1:0]  res_re;
    logic [W-1:0]  res_im;
    logic [PW-1:0] den;
    logic [W-1:0]  lo_re;
    logic [W-1:0]  lo_im;
    logic [PW-1:0] r_re;
    logic [PW-1:0] r_im;
    logic [W-1:0]  q_re;
    logic [W-1:0]  q_im;
    logic [W+1:0]  rem;
    logic [W-1:0]  root;
  } stage_t;

  stage_t         st_d [N];
  stage_t         st_q [N];
  logic [N-1:0]   v_q;
  logic [N-1:0]   en;

  assign ready_o = en[0];
  assign valid_o = v_q[N-1];

  // setup: top of the shifted numerator is the first partial remainder
  logic [XW-1:0] x_re, x_im;
  logic [W+F-1:0] t_re, t_im;

  always_comb begin
    x_re = XW'(num_re_i) << F;
    x_im = XW'(num_im_i) << F;
    t_re = x_re[XW-1:W];
    t_im = x_im[XW-1:W];
    st_d[0]            = '0;
    st_d[0].ctl        = ctl_i;
    st_d[0].ctl.big_re = XW'(t_re) >= XW'(den_i);
    st_d[0].ctl.big_im = XW'(t_im) >= XW'(den_i);
    st_d[0].res_re     = res_re_i;
    st_d[0].res_im     = res_im_i;
    st_d[0].den        = den_i;
    st_d[0].lo_re      = x_re[W-1:0];
    st_d[0].lo_im      = x_im[W-1:0];
    st_d[0].r_re       = PW'(t_re);
    st_d[0].r_im       = PW'(t_im);
  end

  for (genvar k = 1; k < N; k++) begin : g_step
    localparam int unsigned B = N - 1 - k;
    logic [PW:0]  rr_sh, ri_sh, den_x;
    logic [W+3:0] rem_sh, trial;
    logic         ge_r, ge_i, ge_s;

    always_comb begin
      st_d[k] = st_q[k-1];
      den_x   = {1'b0, st_q[k-1].den};
      rr_sh   = {st_q[k-1].r_re, st_q[k-1].lo_re[B]};
      ri_sh   = {st_q[k-1].r_im, st_q[k-1].lo_im[B]};
      ge_r    = rr_sh >= den_x;
      ge_i    = ri_sh >= den_x;
      if (ge_r) rr_sh = rr_sh - den_x;
      if (ge_i) ri_sh = ri_sh - den_x;
      st_d[k].r_re = rr_sh[PW-1:0];
      st_d[k].r_im = ri_sh[PW-1:0];
      st_d[k].q_re = {st_q[k-1].q_re[W-2:0], ge_r};
      st_d[k].q_im = {st_q[k-1].q_im[W-2:0], ge_i};
      rem_sh = {st_q[k-1].rem, st_q[k-1].den[2*B+1:2*B]};
      trial  = (W+4)'({st_q[k-1].root, 2'b01});
      ge_s   = rem_sh >= trial;
      if (ge_s) rem_sh = rem_sh - trial;
      st_d[k].rem  = rem_sh[W+1:0];
      st_d[k].root = {st_q[k-1].root[W-2:0], ge_s};
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_reg
    if (k == N - 1) begin : g_last
      assign en[k] = !v_q[k] || ready_i;
    end else begin : g_mid
      assign en[k] = !v_q[k] || en[k+1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= (k == 0) ? valid_i : v_q[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) st_q[k] <= st_d[k];
    end
  end

  assign ctl_o    = st_q[N-1].ctl;
  assign res_re_o = $signed(st_q[N-1].res_re);
  assign res_im_o = $signed(st_q[N-1].res_im);
  assign q_re_o   = st_q[N-1].q_re;
  assign q_im_o   = st_q[N-1].q_im;
  assign root_o   = st_q[N-1].root;

endmodule

/* rtl/core/cau_back.sv */
// Output stage of the complex arithmetic unit: signs and saturates the
// divide and magnitude results and selects the final word. Depends on cau_pkg.
module cau_back
  import cau_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  ctl_t                        ctl_i,
  input  logic signed [WORD_BITS-1:0] res_re_i,
  input  logic signed [WORD_BITS-1:0] res_im_i,
  input  logic [WORD_BITS-1:0]        q_re_i,
  input  logic [WORD_BITS-1:0]        q_im_i,
  input  logic [WORD_BITS-1:0]        root_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic signed [WORD_BITS-1:0] res_re_o,
  output logic signed [WORD_BITS-1:0] res_im_o,
  output status_e                     status_o
);

  localparam int unsigned W = WORD_BITS;
  localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W:0] sat_mag(input logic neg, input logic big,
                                         input logic [W-1:0] m);
    logic [W-1:0] lim;
    logic [W-1:0] mag;
    logic         over;
    lim  = neg ? LIM_NEG : LIM_POS;
    over = big || (m > lim);
    mag  = over ? lim : m;
    return {over, neg ? (~mag + 1'b1) : mag};
  endfunction

  logic       v_q, en;
  logic [W:0] s_re, s_im;
  logic [W-1:0] re_d, im_d;
  status_e    st_d;

  assign en      = !v_q || ready_i;
  assign ready_o = en;
  assign valid_o = v_q;

  always_comb begin
    s_re = '0;
    s_im = '0;
    re_d = res_re_i;
    im_d = res_im_i;
    st_d = ctl_i.status;
    unique case (ctl_i.cmd)
      CMD_DIV: begin
        if (ctl_i.status != ST_DIV0) begin
          s_re = sat_mag(ctl_i.neg_re, ctl_i.big_re, q_re_i);
          s_im = sat_mag(ctl_i.neg_im, ctl_i.big_im, q_im_i);
          re_d = s_re[W-1:0];
          im_d = s_im[W-1:0];
          st_d = (s_re[W] || s_im[W]) ? ST_OVF : ST_OK;
        end
      end
      CMD_MAG: begin
        s_re = sat_mag(1'b0, 1'b0, root_i);
        re_d = s_re[W-1:0];
        im_d = '0;
        st_d = s_re[W] ? ST_OVF : ST_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_re_o <= re_d;
      res_im_o <= im_d;
      status_o <= st_d;
    end
  end

endmodule

/* rtl/core/complex_arith_unit_core.sv */
// Top level of the complex arithmetic unit: stream ports around the front,
// bit-per-stage and output pipelines. Depends on cau_pkg and the defines header.
//
// Complex ALU on signed fixed point (Q16.16 by default): add, subtract,
// multiply, divide and magnitude of A, one result with status per request.
// Fully pipelined: a new request may enter every cycle unless backpressure
// stalls the pipeline. From input to output each request passes four
// front stages for operands, products and sums, a setup stage plus WORD_BITS
// stages of divide and square root that settle one quotient or root bit each,
// and the output register. Backpressure stalls only the stages that hold requests.
`include "complex_arith_unit_core_defines.svh"

module complex_arith_unit_core
  import cau_pkg::*;
#(
  parameter int unsigned WORD_BITS     = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // operand_a_real, operand_a_imag, operand_b_real, operand_b_imag
  input  logic [((4*WORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // command
  input  logic [CMD_BITS-1:0]                   s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // result_real, result_imag
  output logic [((2*WORD_BITS+7)/8)*8-1:0]      m_axis_tdata,
  // status
  output logic [STATUS_BITS-1:0]                m_axis_tuser
);

  localparam int unsigned W      = WORD_BITS;
  localparam int unsigned OUT_TW = ((2*WORD_BITS+7)/8)*8;
  localparam logic [W-1:0] WMAX  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN  = {1'b1, {(W-1){1'b0}}};

  logic               f_valid, f_ready, i_valid, i_ready;
  ctl_t               f_ctl, i_ctl;
  logic signed [W-1:0] f_re, f_im, i_re, i_im, o_re, o_im;
  logic [2*W-1:0]     f_num_re, f_num_im, f_den;
  logic [W-1:0]       q_re, q_im, root;
  status_e            o_status;

  cau_front #(
    .WORD_BITS    (WORD_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .cmd_i   (s_axis_tuser),
    .a_re_i  (s_axis_tdata[W-1:0]),
    .a_im_i  (s_axis_tdata[2*W-1:W]),
    .b_re_i  (s_axis_tdata[3*W-1:2*W]),
    .b_im_i  (s_axis_tdata[4*W-1:3*W]),
    .valid_o (f_valid),
    .ready_i (f_ready),
    .ctl_o   (f_ctl),
    .res_re_o(f_re),
    .res_im_o(f_im),
    .num_re_o(f_num_re),
    .num_im_o(f_num_im),
    .den_o   (f_den)
  );

  cau_iter #(
    .WORD_BITS    (WORD_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_iter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .ctl_i   (f_ctl),
    .res_re_i(f_re),
    .res_im_i(f_im),
    .num_re_i(f_num_re),
    .num_im_i(f_num_im),
    .den_i   (f_den),
    .valid_o (i_valid),
    .ready_i (i_ready),
    .ctl_o   (i_ctl),
    .res_re_o(i_re),
    .res_im_o(i_im),
    .q_re_o  (q_re),
    .q_im_o  (q_im),
    .root_o  (root)
  );

  cau_back #(
    .WORD_BITS(WORD_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (i_valid),
    .ready_o (i_ready),
    .ctl_i   (i_ctl),
    .res_re_i(i_re),
    .res_im_i(i_im),
    .q_re_i  (q_re),
    .q_im_i  (q_im),
    .root_i  (root),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_re_o(o_re),
    .res_im_o(o_im),
    .status_o(o_status)
  );

  assign m_axis_tdata = OUT_TW'({o_im, o_re});
  assign m_axis_tuser = o_status;

  `CAU_ASSERT_IMP(a_div0_zero, m_axis_tvalid && (m_axis_tuser == ST_DIV0), (o_re == '0) && (o_im == '0), "divide by zero result not zero")
  `CAU_ASSERT_IMP(a_ovf_sat, m_axis_tvalid && (m_axis_tuser == ST_OVF), (o_re == WMAX) || (o_re == WMIN) || (o_im == WMAX) || (o_im == WMIN), "overflow without saturated part")
  `CAU_ASSERT_IMP(a_stall_src, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled while output free")
  `CAU_ASSERT_NXT(a_full_holds, !s_axis_tready, m_axis_tvalid, "full pipeline lost its output")

endmodule
